FILE: hdl/ecbid_pkg.sv
// Shared types and constants for the EC board ID query sequencer.
// No dependencies; imported by every module of the block.
package ecbid_pkg;

    localparam int LIMIT_W = 18;
    localparam int WAIT_W  = LIMIT_W + 1;   // limit plus one handshake step of headroom
    localparam int CMD_W   = 8;
    localparam int IDX_W   = 2;

    localparam logic [WAIT_W-1:0]  HANDSHAKE_STEP = WAIT_W'(10);
    localparam logic [WAIT_W-1:0]  BYTE_STEP      = WAIT_W'(1);
    localparam logic [7:0]         FAIL_ID        = 8'hFF;
    localparam logic [4:0]         ID_MASK        = 5'h1F;

    localparam int OBF_BIT = 0;
    localparam int IBF_BIT = 1;

    localparam logic [LIMIT_W-1:0] TIMEOUT_RST = LIMIT_W'(131072);
    localparam logic [CMD_W-1:0]   WAKE_RST    = 8'h2D;
    localparam logic [CMD_W-1:0]   QUERY_RST   = 8'h0D;

    // register indexes on the config port
    localparam logic [IDX_W-1:0] REG_TIMEOUT = 2'd0;
    localparam logic [IDX_W-1:0] REG_WAKE    = 2'd1;
    localparam logic [IDX_W-1:0] REG_QUERY   = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_DISCARD = 2'd1,
        OP_WRITE   = 2'd2,
        OP_KEEP    = 2'd3
    } op_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] timeout_limit;
        logic [CMD_W-1:0]   wake_command;
        logic [CMD_W-1:0]   query_command;
    } cfg_t;

endpackage

FILE: hdl/ecbid_cfg.sv
// Configuration register file: timeout limit and the two command bytes.
// Depends on ecbid_pkg.
module ecbid_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ecbid_pkg::IDX_W-1:0]  cfg_index,
    input  logic [ecbid_pkg::LIMIT_W-1:0] cfg_data,
    output ecbid_pkg::cfg_t              cfg
);
    import ecbid_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_limit <= TIMEOUT_RST;
            cfg_reg.wake_command  <= WAKE_RST;
            cfg_reg.query_command <= QUERY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TIMEOUT: cfg_reg.timeout_limit <= cfg_data;
                REG_WAKE:    cfg_reg.wake_command  <= cfg_data[CMD_W-1:0];
                REG_QUERY:   cfg_reg.query_command <= cfg_data[CMD_W-1:0];
                default:     ;  // unmapped index, ignored
            endcase
        end
    end

endmodule

FILE: hdl/ecbid_core.sv
// Sequencer core: input register, handshake FSM with wait counter, result register.
// Depends on ecbid_pkg.
module ecbid_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ecbid_pkg::cfg_t            cfg,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       action,
    input  logic [7:0]                 ec_status,
    input  logic [7:0]                 ec_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 port_op,
    output logic [ecbid_pkg::CMD_W-1:0] command_byte,
    output logic                       done_res,
    output logic                       timed_out,
    output logic [7:0]                 board_id
);
    import ecbid_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_DRAIN  = 3'd1,
        PH_INWAIT = 3'd2,
        PH_BYTE1  = 3'd3,
        PH_BYTE2  = 3'd4
    } phase_t;

    // input stage
    logic        s1_valid_reg;
    logic        s1_action_reg;
    logic [7:0]  s1_status_reg;
    logic [7:0]  s1_data_reg;
    logic        advance;

    // sequencer state
    phase_t              phase_reg, phase_next;
    logic [WAIT_W-1:0]   wc_reg, wc_next;
    logic                ci_reg, ci_next;

    // step result
    op_t                 res_op;
    logic [CMD_W-1:0]    res_cmd;
    logic                res_done;
    logic                res_to;
    logic [7:0]          res_id;

    // output stage
    logic                out_valid_reg;
    op_t                 op_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic                done_reg;
    logic                to_reg;
    logic [7:0]          id_reg;

    logic                obf, ibf;
    logic [WAIT_W-1:0]   limit_ext;
    logic [WAIT_W-1:0]   iw_count;
    logic                wc_lt, iw_lt;
    logic                fail;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;

    always_comb
    begin
        phase_next = phase_reg;
        wc_next    = wc_reg;
        ci_next    = ci_reg;
        res_op     = OP_NONE;
        res_cmd    = '0;
        res_done   = 1'b0;
        res_to     = 1'b0;
        res_id     = '0;
        fail       = 1'b0;

        obf       = s1_status_reg[OBF_BIT];
        ibf       = s1_status_reg[IBF_BIT];
        limit_ext = {1'b0, cfg.timeout_limit};
        wc_lt     = wc_reg < limit_ext;
        // drain hands over to the input wait with a cleared counter
        iw_count  = (phase_reg == PH_DRAIN) ? '0 : wc_reg;
        iw_lt     = iw_count < limit_ext;

        if (s1_action_reg)
        begin
            phase_next = PH_DRAIN;
            wc_next    = '0;
            ci_next    = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_DRAIN, PH_INWAIT:
                begin
                    if (phase_reg == PH_DRAIN && obf && wc_lt)
                    begin
                        wc_next = wc_reg + HANDSHAKE_STEP;
                        res_op  = OP_DISCARD;
                    end
                    else if (phase_reg == PH_DRAIN && !wc_lt)
                        fail = 1'b1;
                    else if (ibf && iw_lt)
                    begin
                        wc_next    = iw_count + HANDSHAKE_STEP;
                        phase_next = PH_INWAIT;
                    end
                    else if (!iw_lt)
                        fail = 1'b1;
                    else
                    begin
                        res_op  = OP_WRITE;
                        res_cmd = ci_reg ? cfg.query_command : cfg.wake_command;
                        wc_next = '0;
                        if (!ci_reg)
                        begin
                            ci_next    = 1'b1;
                            phase_next = PH_DRAIN;
                        end
                        else
                            phase_next = PH_BYTE1;
                    end
                end
                PH_BYTE1, PH_BYTE2:
                begin
                    if (!obf && wc_lt)
                        wc_next = wc_reg + BYTE_STEP;
                    else if (!wc_lt)
                        fail = 1'b1;
                    else
                    begin
                        // high byte is read and dropped: only the low five bits form the id
                        res_op  = OP_KEEP;
                        wc_next = '0;
                        if (phase_reg == PH_BYTE1)
                            phase_next = PH_BYTE2;
                        else
                        begin
                            phase_next = PH_IDLE;
                            res_done   = 1'b1;
                            res_id     = {3'b000, s1_data_reg[4:0] & ID_MASK};
                        end
                    end
                end
                default:
                    phase_next = PH_IDLE;
            endcase

            if (fail)
            begin
                phase_next = PH_IDLE;
                wc_next    = '0;
                res_done   = 1'b1;
                res_to     = 1'b1;
                res_id     = FAIL_ID;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            wc_reg        <= '0;
            ci_reg        <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                phase_reg <= phase_next;
                wc_reg    <= wc_next;
                ci_reg    <= ci_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_action_reg <= action;
            s1_status_reg <= ec_status;
            s1_data_reg   <= ec_data;
        end
        if (advance)
        begin
            op_reg   <= res_op;
            cmd_reg  <= res_cmd;
            done_reg <= res_done;
            to_reg   <= res_to;
            id_reg   <= res_id;
        end
    end

    assign out_valid    = out_valid_reg;
    assign port_op      = op_reg;
    assign command_byte = cmd_reg;
    assign done_res     = done_reg;
    assign timed_out    = to_reg;
    assign board_id     = id_reg;

endmodule

FILE: hdl/ec_board_id_query_sequencer_top.sv
// EC board ID query sequencer, top level.
// Depends on ecbid_pkg, ecbid_cfg and ecbid_core.
//
// Usage:
//   Input channel (in_valid / in_stall): one word per poll. action=1 starts a
//   new query (abandoning any running one); action=0 is a poll carrying the
//   EC status byte and the byte a data-port read would return right now.
//   Output channel (out_valid / out_stall): exactly one result word per input
//   word, in order. port_op tells the host which port access to perform
//   (discard read, command write with command_byte, kept read); done_res and
//   timed_out flag the end of a query, board_id carries the id or 0xFF.
//   Config channel (cfg_valid / cfg_ready): index 0 timeout limit, 1 wake
//   command, 2 query command; cfg_ready is always high. Write only while the
//   block is idle.
// Timing:
//   out_valid rises once an accepted word has landed in the input register
//   and its sequencer step has been loaded into the result register. While
//   out_stall is low, throughput is one word per cycle; the wait counter and
//   phase update in the same cycle as the step, so the next word can follow
//   at once.
// Stall: while out_stall holds a result, one more input word is taken into
//   the input register; in_stall rises only when both stages are full.
// Reset: asynchronous, active low. Sequencer returns to idle, config
//   registers take their defaults (0x20000, 0x2D, 0x0D), both stages empty.
module ec_board_id_query_sequencer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  logic [7:0]                    ec_status,
    input  logic [7:0]                    ec_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    port_op,
    output logic [ecbid_pkg::CMD_W-1:0]   command_byte,
    output logic                          done_res,
    output logic                          timed_out,
    output logic [7:0]                    board_id,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ecbid_pkg::IDX_W-1:0]   cfg_index,
    input  logic [ecbid_pkg::LIMIT_W-1:0] cfg_data
);
    import ecbid_pkg::*;

    cfg_t cfg;

    ecbid_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ecbid_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .ec_status    (ec_status),
        .ec_data      (ec_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .port_op      (port_op),
        .command_byte (command_byte),
        .done_res     (done_res),
        .timed_out    (timed_out),
        .board_id     (board_id)
    );

    // a timeout result carries no port access and the failure id
    a_timeout_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && timed_out |-> done_res && port_op == OP_NONE && board_id == FAIL_ID)
        else $error("timeout word malformed");

    // a successful finish is always the second kept read
    a_done_on_keep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res && !timed_out |-> port_op == OP_KEEP && board_id[7:5] == 3'b000)
        else $error("query finished without a kept read");

    // command byte only accompanies a command write
    a_cmd_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && port_op != OP_WRITE |-> command_byte == '0)
        else $error("command byte outside a write");

    // input backpressure only when the result stage is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with free result stage");

endmodule

FILE: bench/tb_top.sv
// Testbench for ec_board_id_query_sequencer_top: queued stimulus, a predictor of the EC
// query sequence, and word-by-word checking of every result.
// Depends on ecbid_pkg and the RTL of the block; nothing else.
`timescale 1ns / 100ps

module tb_top;
    import ecbid_pkg::*;

    localparam int HOLD_CYCLES   = 80;     // long receiver hold-off, in cycles
    localparam int IDLE_PCT      = 15;     // random idle share on each side
    localparam int SETTLE_CYCLES = 6;      // pipeline is two stages deep
    localparam int ANY           = -1;     // status bit left random

    // sequencer phases, mirrored on our side
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_DRAIN  = 3'd1,
        PH_INWAIT = 3'd2,
        PH_BYTE1  = 3'd3,
        PH_BYTE2  = 3'd4
    } seq_phase_t;

    typedef struct packed {
        logic       action;
        logic [7:0] status;
        logic [7:0] data;
    } poll_word_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] cmd;
        logic       done;
        logic       to;
        logic [7:0] id;
    } query_result_t;

    // ------------------------------------------------------------------
    // Clock, reset and block ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               action       = 1'b0;
    logic [7:0]         ec_status    = 8'h00;
    logic [7:0]         ec_data      = 8'h00;
    logic               out_stall    = 1'b0;
    logic               cfg_valid    = 1'b0;
    logic [IDX_W-1:0]   cfg_index    = REG_TIMEOUT;
    logic [LIMIT_W-1:0] cfg_data     = '0;
    logic               in_stall;
    logic               out_valid;
    logic [1:0]         port_op;
    logic [CMD_W-1:0]   command_byte;
    logic               done_res;
    logic               timed_out;
    logic [7:0]         board_id;
    logic               cfg_ready;

    always #5 clk = ~clk;

    ec_board_id_query_sequencer_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .ec_status    (ec_status),
        .ec_data      (ec_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .port_op      (port_op),
        .command_byte (command_byte),
        .done_res     (done_res),
        .timed_out    (timed_out),
        .board_id     (board_id),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the registers and the sequencer.
    // ------------------------------------------------------------------
    logic [LIMIT_W-1:0] cfg_limit = TIMEOUT_RST;
    logic [CMD_W-1:0]   cfg_wake  = WAKE_RST;
    logic [CMD_W-1:0]   cfg_query = QUERY_RST;

    seq_phase_t         seq_phase     = PH_IDLE;
    logic [WAIT_W-1:0]  seq_wait      = '0;
    logic               seq_cmd_sel   = 1'b0;
    logic [7:0]         seq_high_byte = 8'h00;

    poll_word_t    pending_words[$];
    query_result_t expected_results[$];

    int  words_queued  = 0;
    int  word_budget   = -1;    // >0 cuts a query short, -1 means no cut
    int  mismatches    = 0;
    int  results_seen  = 0;
    int  queries_ok    = 0;
    int  queries_lost  = 0;
    bit  word_taken    = 1'b0;  // input word accepted at the last rising edge
    bit  no_idle       = 1'b0;  // stretch with neither side idling
    bit  hold_go       = 1'b0;
    logic receiver_hold = 1'b0;

    // One poll or start word through the sequencer. Every word yields one result.
    function automatic query_result_t step_sequencer(input poll_word_t w);
        query_result_t r;
        bit            failed;
        bit            go_on;
        r      = '{op: OP_NONE, cmd: 8'h00, done: 1'b0, to: 1'b0, id: 8'h00};
        failed = 1'b0;
        go_on  = 1'b1;
        if (w.action) begin
            // start, also abandons a running query
            seq_phase     = PH_DRAIN;
            seq_wait      = '0;
            seq_cmd_sel   = 1'b0;
            seq_high_byte = 8'h00;
            return r;
        end
        case (seq_phase)
            PH_DRAIN, PH_INWAIT:
            begin
                if (seq_phase == PH_DRAIN) begin
                    if (w.status[OBF_BIT] && seq_wait < WAIT_W'(cfg_limit)) begin
                        seq_wait += HANDSHAKE_STEP;
                        r.op  = OP_DISCARD;
                        go_on = 1'b0;
                    end else if (seq_wait >= WAIT_W'(cfg_limit)) begin
                        failed = 1'b1;
                        go_on  = 1'b0;
                    end else begin
                        // output buffer empty: same status feeds the input wait
                        seq_wait  = '0;
                        seq_phase = PH_INWAIT;
                    end
                end
                if (go_on) begin
                    if (w.status[IBF_BIT] && seq_wait < WAIT_W'(cfg_limit)) begin
                        seq_wait += HANDSHAKE_STEP;
                    end else if (seq_wait >= WAIT_W'(cfg_limit)) begin
                        failed = 1'b1;
                    end else begin
                        r.op     = OP_WRITE;
                        r.cmd    = seq_cmd_sel ? cfg_query : cfg_wake;
                        seq_wait = '0;
                        if (!seq_cmd_sel) begin
                            seq_cmd_sel = 1'b1;
                            seq_phase   = PH_DRAIN;
                        end else begin
                            seq_phase = PH_BYTE1;
                        end
                    end
                end
            end
            PH_BYTE1, PH_BYTE2:
            begin
                if (!w.status[OBF_BIT] && seq_wait < WAIT_W'(cfg_limit)) begin
                    seq_wait += BYTE_STEP;
                end else if (seq_wait >= WAIT_W'(cfg_limit)) begin
                    failed = 1'b1;
                end else begin
                    seq_wait = '0;
                    r.op     = OP_KEEP;
                    if (seq_phase == PH_BYTE1) begin
                        seq_high_byte = w.data;
                        seq_phase     = PH_BYTE2;
                    end else begin
                        seq_phase = PH_IDLE;
                        r.done    = 1'b1;
                        r.id      = {3'b000, w.data[4:0] & ID_MASK};
                    end
                end
            end
            default:
                seq_phase = PH_IDLE;
        endcase
        if (failed) begin
            seq_phase = PH_IDLE;
            seq_wait  = '0;
            r = '{op: OP_NONE, cmd: 8'h00, done: 1'b1, to: 1'b1, id: FAIL_ID};
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic queue_word(input logic act, input logic [7:0] st, input logic [7:0] dt);
        if (word_budget != 0) begin
            pending_words.push_back('{action: act, status: st, data: dt});
            words_queued++;
            if (word_budget > 0)
                word_budget--;
        end
    endtask

    // poll with chosen buffer flags; other status bits and data random
    task automatic poll_with(input int obf, input int ibf);
        logic [7:0] st;
        st = 8'($urandom);
        if (obf != ANY)
            st[OBF_BIT] = obf[0];
        if (ibf != ANY)
            st[IBF_BIT] = ibf[0];
        queue_word(1'b0, st, 8'($urandom));
    endtask

    // mostly short waits, now and then one long enough to run out the limit
    function automatic int wait_len(input int max_wait);
        if ($urandom_range(99) < 85)
            return int'($urandom_range(2));
        return int'($urandom_range(max_wait));
    endfunction

    // a well-formed query with random waits and payload
    task automatic add_query(input int max_wait);
        queue_word(1'b1, 8'($urandom), 8'($urandom));
        for (int c = 0; c < 2; c++) begin
            repeat (wait_len(max_wait)) poll_with(1, ANY);   // drain output buffer
            repeat (wait_len(max_wait)) poll_with(0, 1);     // input buffer busy
            poll_with(0, 0);                                  // command goes out
        end
        for (int b = 0; b < 2; b++) begin
            repeat (wait_len(max_wait)) poll_with(0, ANY);
            poll_with(1, ANY);
        end
    endtask

    task automatic add_random(input int n_words, input int max_wait);
        int target;
        target = words_queued + n_words;
        while (words_queued < target) begin
            if ($urandom_range(99) < 80) begin
                // one in ten queries is cut short and abandoned by the next start
                if ($urandom_range(9) == 0)
                    word_budget = int'($urandom_range(8, 1));
                add_query(max_wait);
                word_budget = -1;
            end else begin
                queue_word($urandom_range(9) == 0, 8'($urandom), 8'($urandom));
            end
        end
    endtask

    // Sender pause: nothing left to send and every result back, then settle.
    // Checked again after settling, since the driver may pop the last word on
    // the very edge this loop looks at.
    task automatic wait_idle();
        do begin
            while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_TIMEOUT: cfg_limit = val;
            REG_WAKE:    cfg_wake  = val[CMD_W-1:0];
            REG_QUERY:   cfg_query = val[CMD_W-1:0];
            default:     ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [LIMIT_W-1:0] lim, input logic [7:0] wake,
                              input logic [7:0] query);
        write_reg(REG_TIMEOUT, lim);
        // upper data bits are don't-care for the command registers
        write_reg(REG_WAKE,  {10'($urandom), wake});
        write_reg(REG_QUERY, {10'($urandom), query});
    endtask

    // ------------------------------------------------------------------
    // Driver: presents the next queued word at the falling edge once the
    // previous one was taken; holds the payload while stalled.
    // ------------------------------------------------------------------
    always @(negedge clk) begin : driver_blk
        poll_word_t w;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || word_taken) begin
            if (pending_words.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                w = pending_words.pop_front();
                in_valid  <= 1'b1;
                action    <= w.action;
                ec_status <= w.status;
                ec_data   <= w.data;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random, or forced high during the long hold-off.
    always @(negedge clk) begin
        out_stall <= receiver_hold || (!no_idle && $urandom_range(99) < IDLE_PCT);
    end

    // Long hold-off, counted here; the sender keeps offering words meanwhile
    // so both pipeline stages fill and in_stall has to rise.
    initial begin
        wait (hold_go);
        @(posedge clk);
        receiver_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        receiver_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted input word, then checks every
    // accepted result word against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : monitor_blk
        query_result_t want;
        poll_word_t    got_in;
        if (!rst_n) begin
            word_taken = 1'b0;
        end else begin
            word_taken = in_valid && !in_stall;
            if (word_taken) begin
                got_in = '{action: action, status: ec_status, data: ec_data};
                expected_results.push_back(step_sequencer(got_in));
            end
            if (out_valid && !out_stall) begin
                results_seen++;
                if (done_res && !timed_out)
                    queries_ok++;
                if (timed_out)
                    queries_lost++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result word with nothing expected (op %0d)",
                                              port_op));
                end else begin
                    want = expected_results.pop_front();
                    if (port_op !== want.op)
                        report_mismatch($sformatf("port_op got %0d want %0d",
                                                  port_op, want.op));
                    if (command_byte !== want.cmd)
                        report_mismatch($sformatf("command_byte got %02h want %02h",
                                                  command_byte, want.cmd));
                    if (done_res !== want.done)
                        report_mismatch($sformatf("done_res got %0b want %0b",
                                                  done_res, want.done));
                    if (timed_out !== want.to)
                        report_mismatch($sformatf("timed_out got %0b want %0b",
                                                  timed_out, want.to));
                    if (board_id !== want.id)
                        report_mismatch($sformatf("board_id got %02h want %02h",
                                                  board_id, want.id));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset register values: poll while idle, a full query with
        // drain, input wait and both bytes, then start while busy.
        queue_word(1'b0, 8'h03, 8'hA5);
        queue_word(1'b1, 8'hFF, 8'hFF);
        queue_word(1'b0, 8'hFF, 8'h00);   // discard read
        queue_word(1'b0, 8'h02, 8'h5A);   // drain done, input still busy
        queue_word(1'b0, 8'h00, 8'h00);   // wake command
        queue_word(1'b0, 8'h01, 8'h11);   // discard before second command
        queue_word(1'b0, 8'hFC, 8'h22);   // query command via fall-through
        queue_word(1'b0, 8'h00, 8'h33);   // byte wait
        queue_word(1'b0, 8'h01, 8'hFF);   // high byte
        queue_word(1'b0, 8'hFE, 8'h44);
        queue_word(1'b0, 8'hFD, 8'h00);   // low byte, id 0
        queue_word(1'b0, 8'h01, 8'h7F);   // idle again
        queue_word(1'b1, 8'h00, 8'h00);
        queue_word(1'b0, 8'h00, 8'h9E);
        queue_word(1'b1, 8'h55, 8'hAA);   // abandon the running query
        queue_word(1'b0, 8'h02, 8'h00);
        queue_word(1'b1, 8'hAA, 8'h55);
        wait_idle();

        // Zero limit: first wait fails even with the EC ready.
        set_config('0, 8'h00, 8'hFF);
        queue_word(1'b1, 8'h00, 8'h00);
        queue_word(1'b0, 8'h00, 8'h1F);
        queue_word(1'b1, 8'h00, 8'h00);
        queue_word(1'b0, 8'h01, 8'hE0);
        queue_word(1'b0, 8'h00, 8'hFF);   // poll after timeout
        wait_idle();

        // Small limit with long waits: timeouts now and then in each kind of wait.
        set_config(LIMIT_W'(40), 8'($urandom), 8'($urandom));
        add_random(160, 45);
        wait_idle();

        // Largest limit and extreme commands, no idling on either side.
        set_config({LIMIT_W{1'b1}}, 8'hFF, 8'h00);
        no_idle = 1'b1;
        add_random(160, 8);
        wait_idle();
        no_idle = 1'b0;

        // Limit of one: every wait fails on its second poll.
        set_config(LIMIT_W'(1), 8'($urandom), 8'($urandom));
        add_random(160, 3);
        wait_idle();

        // Receiver hold-off while the sender keeps pushing.
        set_config(LIMIT_W'(100), 8'($urandom), 8'($urandom));
        add_random(160, 15);
        hold_go = 1'b1;
        wait_idle();

        set_config(LIMIT_W'($urandom_range(200)), 8'($urandom), 8'($urandom));
        add_random(160, 25);
        wait_idle();

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        $display("Summary: %0d words over seven register settings, %0d results checked,",
                 words_queued, results_seen);
        $display("         %0d queries completed, %0d ended by timeout, %0d mismatches",
                 queries_ok, queries_lost, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("Timeout: results still outstanding");
        $display("Verification failed");
        $finish;
    end

endmodule
